@@ rtl/dstq_pkg.sv @@
`default_nettype none
package dstq_pkg;

    localparam int DEPTH = 16;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int MAX_OUT = 16;
    localparam int OUTN_W = $clog2(MAX_OUT + 1);
    localparam logic [15:0] IDLE_RESET = 16'd100;

    typedef enum logic [2:0] {
        OP_INSERT = 3'd0,
        OP_DETACH = 3'd1,
        OP_POLL   = 3'd2,
        OP_EXPIRE = 3'd3,
        OP_FLUSH  = 3'd4,
        OP_TICK   = 3'd5
    } op_t;

    localparam logic [2:0] K_INSERTED = 3'd0;
    localparam logic [2:0] K_FULL     = 3'd1;
    localparam logic [2:0] K_DETACHED = 3'd2;
    localparam logic [2:0] K_NOTFOUND = 3'd3;
    localparam logic [2:0] K_EXPIRED  = 3'd4;
    localparam logic [2:0] K_WAIT     = 3'd5;
    localparam logic [2:0] K_NOTHING  = 3'd6;

    // Command broadcast from the controller to every cell.
    typedef enum logic [2:0] {
        CC_HOLD   = 3'd0,
        CC_INSERT = 3'd1,
        CC_REMOVE = 3'd2
    } cell_cmd_t;

    typedef struct packed {
        cell_cmd_t   cmd;
        logic [31:0] id;
        logic [31:0] deadline;
        logic [31:0] match_id;
    } cell_ctl_t;

    typedef struct packed {
        logic [31:0] id;
        logic [31:0] deadline;
    } entry_t;

endpackage
`default_nettype wire

@@ rtl/dstq_cell.sv @@
`default_nettype none
// One slot of the sorted row. On insert a cell keeps its entry, takes the new one,
// or takes its left neighbor's entry; on remove a hit cell takes its right neighbor's.
module dstq_cell
    import dstq_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire cell_ctl_t ctl,
    input  wire logic      left_valid,
    input  wire logic      left_ahead,
    input  wire entry_t    left_entry,
    input  wire entry_t    right_entry,
    input  wire logic      right_valid,
    input  wire logic      left_hit,
    output logic           valid,
    output logic           ahead,
    output logic           hit,
    output entry_t         entry
);

    entry_t entry_reg;
    logic   valid_reg;
    logic   earlier_new;

    // Wraparound order: the held deadline is earlier than the new one.
    assign earlier_new = ((entry_reg.deadline - ctl.deadline) >> 31) != 32'd0;
    // Ahead marks an unbroken run of earlier entries from the head, so the new
    // entry lands at the first cell that is not earlier.
    assign ahead = left_ahead && valid_reg && earlier_new;
    // Hit marks the first matching cell and everything right of it.
    assign hit = left_hit || (valid_reg && (entry_reg.id == ctl.match_id));
    assign valid = valid_reg;
    assign entry = entry_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            case (ctl.cmd)
                CC_INSERT:
                begin
                    if (!ahead && left_ahead) valid_reg <= 1'b1;
                    else if (!ahead) valid_reg <= left_valid;
                end
                CC_REMOVE:
                begin
                    if (hit) valid_reg <= right_valid;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (ctl.cmd)
            CC_INSERT:
            begin
                if (!ahead && left_ahead)
                begin
                    entry_reg.id <= ctl.id;
                    entry_reg.deadline <= ctl.deadline;
                end
                else if (!ahead)
                begin
                    entry_reg <= left_entry;
                end
            end
            CC_REMOVE:
            begin
                if (hit) entry_reg <= right_entry;
            end
            default: ;
        endcase
    end

endmodule
`default_nettype wire

@@ rtl/dstq_row.sv @@
`default_nettype none
// Chain of cells; cell 0 is the head of the queue.
module dstq_row
    import dstq_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire cell_ctl_t ctl,
    output entry_t         head,
    output entry_t         next_head,
    output logic           found
);

    logic   v    [DEPTH+1];
    logic   bf   [DEPTH+1];
    logic   ht   [DEPTH+1];
    entry_t e    [DEPTH+1];

    // Boundary: left of the head counts as ahead so the new entry lands at the
    // first cell not earlier; right of the tail is empty.
    assign v[DEPTH] = 1'b0;
    assign e[DEPTH] = '0;

    genvar g;
    generate
        for (g = 0; g < DEPTH; g++)
        begin : g_cell
            logic   lv;
            logic   lb;
            logic   lh;
            entry_t le;
            if (g == 0)
            begin : g_first
                assign lv = 1'b0;
                assign lb = 1'b1;
                assign lh = 1'b0;
                assign le = '0;
            end
            else
            begin : g_rest
                assign lv = v[g-1];
                assign lb = bf[g-1];
                assign lh = ht[g-1];
                assign le = e[g-1];
            end
            dstq_cell u_cell (
                .clk         (clk),
                .rst_n       (rst_n),
                .ctl         (ctl),
                .left_valid  (lv),
                .left_ahead  (lb),
                .left_entry  (le),
                .right_entry (e[g+1]),
                .right_valid (v[g+1]),
                .left_hit    (lh),
                .valid       (v[g]),
                .ahead       (bf[g]),
                .hit         (ht[g]),
                .entry       (e[g])
            );
        end
    endgenerate

    assign bf[DEPTH] = 1'b0;
    assign ht[DEPTH] = ht[DEPTH-1];
    assign head      = e[0];
    assign next_head = e[1];
    assign found     = ht[DEPTH-1];

endmodule
`default_nettype wire

@@ rtl/deadline_sorted_timeout_queue.sv @@
`default_nettype none
// Insert, detach, poll, tick and unknown ops show their first result in the cycle after
// acceptance; expire and flush first enter the walk state, which then registers results.
// A poll that expires the head gives two results, expire and flush up to 16, one head
// removal per cycle through the cell chain while the result register is free.
// A new request is taken only in idle with the result register free.
// Reset clears all cells' valid bits, the counter, now_ms, the output valid and sets idle wait to 100.
module deadline_sorted_timeout_queue
    import dstq_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [63:0] s_tdata,   // req_id[31:0], timeout_ms[62:32]
    input  wire logic [2:0]  s_tuser,   // op[2:0]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [71:0]      m_tdata,   // entry_id[31:0], wait_ms[62:32], occupancy[67:63]
    output logic [2:0]       m_tuser,   // kind[2:0]
    output logic             m_tlast,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [15:0] cfg_data
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_WALK = 3'b010,
        ST_POLL = 3'b100
    } state_t;

    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [31:0]       now_reg, now_next;
    logic [15:0]       idle_reg;
    logic [OUTN_W-1:0] nout_reg, nout_next;
    logic              flush_reg, flush_next;
    logic              ov_reg, ov_next;
    logic [2:0]        ok_reg, ok_next;
    logic [31:0]       oid_reg, oid_next;
    logic [30:0]       ow_reg, ow_next;
    logic [CNT_W-1:0]  oc_reg, oc_next;
    logic              ol_reg, ol_next;

    cell_ctl_t ctl;
    entry_t    head;
    entry_t    next_head;
    logic      found;
    logic      take, slot_free, head_due_exp, next_due_exp;
    logic [2:0]  op;
    logic [31:0] rid, diff, ndl;

    dstq_row u_row (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl),
        .head      (head),
        .next_head (next_head),
        .found     (found)
    );

    assign op   = s_tuser;
    assign rid  = s_tdata[31:0];
    assign slot_free = !ov_reg || m_tready;
    assign s_tready  = (state_reg == ST_IDLE) && slot_free;
    assign take      = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign ndl  = now_reg + {1'b0, s_tdata[62:32]};
    assign diff = head.deadline - now_reg;
    // Expire-due condition on the head: nonzero deadline and already reached.
    assign head_due_exp = (head.deadline != 32'd0) &&
                          (((now_reg - head.deadline) >> 31) == 32'd0);
    // The same test on the entry that becomes the head after a removal.
    assign next_due_exp = (next_head.deadline != 32'd0) &&
                          (((now_reg - next_head.deadline) >> 31) == 32'd0);

    assign m_tvalid = ov_reg;
    assign m_tuser  = ok_reg;
    assign m_tlast  = ol_reg;
    assign m_tdata  = {4'd0, oc_reg, ow_reg, oid_reg};

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        now_next   = now_reg;
        nout_next  = nout_reg;
        flush_next = flush_reg;
        ov_next    = ov_reg && !m_tready;
        ok_next    = ok_reg;
        oid_next   = oid_reg;
        ow_next    = ow_reg;
        oc_next    = oc_reg;
        ol_next    = ol_reg;
        ctl.cmd      = CC_HOLD;
        ctl.id       = rid;
        ctl.deadline = ndl;
        ctl.match_id = rid;

        case (state_reg)
            ST_IDLE:
            begin
                if (take)
                begin
                    ov_next  = 1'b1;
                    ol_next  = 1'b1;
                    oid_next = 32'd0;
                    ow_next  = 31'd0;
                    ok_next  = K_NOTHING;
                    oc_next  = cnt_reg;
                    case (op)
                        OP_INSERT:
                        begin
                            oid_next = rid;
                            if (cnt_reg >= CNT_W'(DEPTH)) ok_next = K_FULL;
                            else
                            begin
                                ctl.cmd  = CC_INSERT;
                                ok_next  = K_INSERTED;
                                cnt_next = cnt_reg + CNT_W'(1);
                                oc_next  = cnt_reg + CNT_W'(1);
                            end
                        end
                        OP_DETACH:
                        begin
                            oid_next = rid;
                            if (found)
                            begin
                                ctl.cmd  = CC_REMOVE;
                                ok_next  = K_DETACHED;
                                cnt_next = cnt_reg - CNT_W'(1);
                                oc_next  = cnt_reg - CNT_W'(1);
                            end
                            else ok_next = K_NOTFOUND;
                        end
                        OP_POLL:
                        begin
                            ok_next = K_WAIT;
                            if (cnt_reg == '0) ow_next = {15'd0, idle_reg};
                            else if (diff == 32'd0 || diff[31])
                            begin
                                ctl.cmd      = CC_REMOVE;
                                ctl.match_id = head.id;
                                ok_next  = K_EXPIRED;
                                oid_next = head.id;
                                ol_next  = 1'b0;
                                cnt_next = cnt_reg - CNT_W'(1);
                                oc_next  = cnt_reg - CNT_W'(1);
                                state_next = ST_POLL;
                            end
                            else ow_next = diff[30:0];
                        end
                        OP_EXPIRE, OP_FLUSH:
                        begin
                            ov_next    = 1'b0;
                            nout_next  = '0;
                            flush_next = (op == OP_FLUSH);
                            state_next = ST_WALK;
                        end
                        OP_TICK: now_next = now_reg + 32'd1;
                        default: ;
                    endcase
                end
            end
            ST_POLL:
            begin
                if (slot_free)
                begin
                    ov_next  = 1'b1;
                    ok_next  = K_WAIT;
                    oid_next = 32'd0;
                    ow_next  = {15'd0, idle_reg};
                    ol_next  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_WALK:
            begin
                if (slot_free)
                begin
                    // Remove the head if due or flushing, one entry per cycle while the result slot is free.
                    if (cnt_reg != '0 && nout_reg < OUTN_W'(MAX_OUT) &&
                        (flush_reg || head_due_exp))
                    begin
                        ctl.cmd      = CC_REMOVE;
                        ctl.match_id = head.id;
                        ov_next  = 1'b1;
                        ok_next  = K_EXPIRED;
                        oid_next = head.id;
                        ow_next  = 31'd0;
                        cnt_next = cnt_reg - CNT_W'(1);
                        oc_next  = cnt_reg - CNT_W'(1);
                        nout_next = nout_reg + OUTN_W'(1);
                        // Last when the limit is reached, the queue empties, or the
                        // entry behind the head is not due.
                        ol_next = (nout_reg == OUTN_W'(MAX_OUT - 1)) ||
                                  (cnt_reg == CNT_W'(1)) ||
                                  (!flush_reg && !next_due_exp);
                        if (ol_next) state_next = ST_IDLE;
                        else
                        begin
                            state_next = ST_WALK;
                        end
                    end
                    else
                    begin
                        // Walk stopped: either end a run or report nothing.
                        if (nout_reg == '0)
                        begin
                            ov_next  = 1'b1;
                            ok_next  = K_NOTHING;
                            oid_next = 32'd0;
                            ow_next  = 31'd0;
                            oc_next  = cnt_reg;
                            ol_next  = 1'b1;
                        end
                        state_next = ST_IDLE;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            now_reg   <= '0;
            idle_reg  <= IDLE_RESET;
            nout_reg  <= '0;
            flush_reg <= 1'b0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            now_reg   <= now_next;
            nout_reg  <= nout_next;
            flush_reg <= flush_next;
            ov_reg    <= ov_next;
            if (cfg_valid && cfg_ready) idle_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk)
    begin
        ok_reg  <= ok_next;
        oid_reg <= oid_next;
        ow_reg  <= ow_next;
        oc_reg  <= oc_next;
        ol_reg  <= ol_next;
    end

    a_occ: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(DEPTH)) else $error("occupancy above depth");
    a_idle_ready: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready |-> state_reg == ST_IDLE) else $error("ready outside idle");
    a_tick: assert property (@(posedge clk) disable iff (!rst_n)
        (take && op == OP_TICK) |=> now_reg == $past(now_reg) + 32'd1)
        else $error("tick did not advance");

endmodule
`default_nettype wire
